// File: rtl/cal_pkg.sv
// Shared types and constants for the compacting array list.
package cal_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 6;
	localparam int FILL_W = 7;

	typedef enum logic [1:0] {
		OP_DISPLAY = 2'd0,
		OP_APPEND  = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_DELETE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISP,
		S_SHIFT
	} state_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] item;
		logic [IDX_W-1:0]         position;
		logic [FILL_W-1:0]        fill;
		logic                     last;
	} rsp_t;

endpackage

// File: rtl/cal_ram.sv
// Entry store: one write port, one registered read port with enable.
module cal_ram #(
	parameter int Width = 32,
	parameter int Depth = 64,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/cal_obuf.sv
// Output register between the sequencer and the result channel.
module cal_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	output logic          res_rdy,
	input  cal_pkg::rsp_t res,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cal_pkg::rsp_t rsp
);
	import cal_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign res_rdy = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_rdy) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && res_valid) begin
			data_q <= res;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = data_q;

endmodule

// File: rtl/compacting_array_list.sv
// Compacting array list: sequencer around a single entry memory.
//
//   channel | direction | word   | handshake
//   req     | in        | req_t  | req_valid / req_stall
//   rsp     | out       | rsp_t  | rsp_valid / rsp_stall
//
// Append, update and any error give their result on acceptance, through one output register.
// Display performs one memory read per entry on the single read port.
// Delete at index i compacts the list by moving each later entry down, one entry per cycle.
// Reset clears the fill count and the sequencer; entries stay undefined until written.
// A stall on rsp holds a display and, with the output register full, stalls req.
// Compaction runs on through a stall on rsp; req is stalled while a display or compaction runs.
module compacting_array_list (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cal_pkg::rsp_t rsp
);
	import cal_pkg::*;

	state_t              state_q, state_d;
	logic [FILL_W-1:0]   count_q;
	logic [ADDR_W-1:0]   ptr_q;

	logic                res_valid, res_rdy;
	rsp_t                res;
	logic                we, re;
	logic [ADDR_W-1:0]   waddr, raddr;
	logic [DATA_W-1:0]   wdata, rdata;

	logic                acc;
	logic [FILL_W-1:0]   idx7, idx_inc, ptr_inc, ptr_inc2;
	logic                idx_ok, disp_last, shift_done, shift_more;

	assign idx7       = FILL_W'(req.index);
	assign idx_inc    = idx7 + FILL_W'(1);
	assign ptr_inc    = FILL_W'(ptr_q) + FILL_W'(1);
	assign ptr_inc2   = FILL_W'(ptr_q) + FILL_W'(2);
	assign idx_ok     = idx7 < count_q;
	assign shift_more = idx_inc < count_q;
	assign disp_last  = ptr_inc == count_q;
	assign shift_done = ptr_inc == count_q;

	assign req_stall = (state_q != S_IDLE) || !res_rdy;
	assign acc       = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && req.op == OP_DISPLAY && count_q != '0) begin
					state_d = S_DISP;
				end else if (acc && req.op == OP_DELETE && idx_ok && shift_more) begin
					state_d = S_SHIFT;
				end
			end
			S_DISP: begin
				if (res_rdy && disp_last) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		we        = 1'b0;
		waddr     = '0;
		wdata     = req.value;
		re        = 1'b0;
		raddr     = '0;
		unique case (state_q)
			S_IDLE: begin
				res.fill = count_q;
				if (acc) begin
					res_valid = 1'b1;
					unique case (req.op)
						OP_DISPLAY: begin
							if (count_q == '0) begin
								res.status = ST_EMPTY;
							end else begin
								res_valid = 1'b0;
								re        = 1'b1;
							end
						end
						OP_APPEND: begin
							if (count_q >= FILL_W'(DEPTH)) begin
								res.status = ST_FULL;
							end else begin
								we       = 1'b1;
								waddr    = ADDR_W'(count_q);
								res.fill = count_q + FILL_W'(1);
							end
						end
						OP_UPDATE: begin
							if (!idx_ok) begin
								res.status = ST_RANGE;
							end else begin
								we    = 1'b1;
								waddr = ADDR_W'(req.index);
							end
						end
						OP_DELETE: begin
							if (!idx_ok) begin
								res.status = ST_RANGE;
							end else begin
								res.fill = count_q - FILL_W'(1);
								if (shift_more) begin
									re    = 1'b1;
									raddr = ADDR_W'(idx_inc);
								end
							end
						end
						default: res.status = ST_OK;
					endcase
				end
			end
			S_DISP: begin
				res_valid    = 1'b1;
				res.item     = rdata;
				res.position = IDX_W'(ptr_q);
				res.fill     = count_q;
				res.last     = disp_last;
				if (res_rdy && !disp_last) begin
					re    = 1'b1;
					raddr = ADDR_W'(ptr_inc);
				end
			end
			S_SHIFT: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = rdata;
				if (!shift_done) begin
					re    = 1'b1;
					raddr = ADDR_W'(ptr_inc2);
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (acc && req.op == OP_DISPLAY) begin
						ptr_q <= '0;
					end
					if (acc && req.op == OP_APPEND && count_q < FILL_W'(DEPTH)) begin
						count_q <= count_q + FILL_W'(1);
					end
					if (acc && req.op == OP_DELETE && idx_ok) begin
						count_q <= count_q - FILL_W'(1);
						ptr_q   <= ADDR_W'(req.index);
					end
				end
				S_DISP: begin
					if (res_rdy && !disp_last) begin
						ptr_q <= ADDR_W'(ptr_inc);
					end
				end
				S_SHIFT: begin
					ptr_q <= ADDR_W'(ptr_inc);
				end
				default: ptr_q <= '0;
			endcase
		end
	end

	cal_ram #(
		.Width(DATA_W),
		.Depth(DEPTH),
		.AddrW(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	cal_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_rdy  (res_rdy),
		.res      (res),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FILL_W'(DEPTH))
		else $error("fill count beyond depth");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && waddr == raddr))
		else $error("read and write to one entry in one cycle");

	a_shift_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> we && FILL_W'(ptr_q) < count_q)
		else $error("compaction write outside the list");

	a_disp_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.op == OP_DISPLAY && count_q != '0 |=> state_q == S_DISP && ptr_q == '0)
		else $error("display did not start at entry zero");

	a_disp_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DISP |-> !we)
		else $error("memory written during display");
`endif

endmodule
